FILE: sv/pqse_pkg.sv
// ----------------------------------------------------------------------------
// pqse_pkg: shared types and constants for the scan-extract priority queue
// Holds the queue depth, derived widths, operation and status codes, and
// the entry and store request types that pass between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pqse_pkg;

	localparam int DEPTH   = 32;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int CMP_W   = CNT_W + 1;          // room for index + 2 compares
	localparam int VALUE_W = 16;
	localparam int PRIO_W  = 8;
	localparam int OP_W    = 2;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 6;                  // width of the reported count

	localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
	localparam logic [OP_W-1:0] OP_EXTRACT = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [PRIO_W-1:0]  prio;
		logic [VALUE_W-1:0] value;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic [IDX_W-1:0] raddr;
	} store_req_t;

endpackage

`default_nettype wire

FILE: sv/pqse_store.sv
// ----------------------------------------------------------------------------
// pqse_store: entry memory of the priority queue
// One write port and one read port, read data registered. Contents are
// undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module pqse_store (
	input  wire                 clk,
	input  pqse_pkg::store_req_t req,
	output pqse_pkg::entry_t     rdata
);
	import pqse_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rdata_q <= mem_q[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: sv/priority_queue_scan_extract.sv
// ----------------------------------------------------------------------------
// priority_queue_scan_extract: bounded priority queue, unsorted array
// Entries sit in arrival order. Add appends at the tail, extract scans for
// the highest priority (earliest wins a tie) and closes the gap by moving
// later entries down, clear empties the queue. One result per transaction.
// ----------------------------------------------------------------------------
//
//  channel | handshake                 | payload
//  --------+---------------------------+---------------------------------------
//  input   | in_valid  / in_stall      | op, item_value, item_priority
//  output  | out_valid / out_stall     | out_value, status, entry_count,
//          |                           | queue_empty, queue_full
//
//  Add, clear, the unused op code and extract on an empty queue go from
//  acceptance straight to the final step. Extract of a queue holding n
//  entries with the winner at index b makes one memory read per entry
//  during the scan, then one read/write pair for each of the n - 1 - b
//  moved entries, all through the store's one write and one read port.
//  in_stall is high from acceptance until the result has been loaded into
//  the output register; a stalled output holds the block in its final step.
//  Reset empties the queue at once; the store itself is never cleared.
//
`default_nettype none

module priority_queue_scan_extract (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire  [pqse_pkg::OP_W-1:0]    op,
	input  wire  [pqse_pkg::VALUE_W-1:0] item_value,
	input  wire  [pqse_pkg::PRIO_W-1:0]  item_priority,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [pqse_pkg::VALUE_W-1:0] out_value,
	output logic [pqse_pkg::STAT_W-1:0]  status,
	output logic [pqse_pkg::COUNT_W-1:0] entry_count,
	output logic                         queue_empty,
	output logic                         queue_full
);
	import pqse_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_FIN
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q;        // fill level
	logic [IDX_W-1:0]     cmp_idx_q;    // index whose read data is arriving
	logic [IDX_W-1:0]     best_idx_q;
	logic [PRIO_W-1:0]    best_pri_q;
	logic [VALUE_W-1:0]   res_val_q;    // value carried into the result
	logic [STAT_W-1:0]    res_stat_q;
	logic [IDX_W-1:0]     sh_idx_q;     // slot being refilled

	logic                 out_valid_q;
	logic [VALUE_W-1:0]   out_value_q;
	logic [STAT_W-1:0]    status_q;
	logic [COUNT_W-1:0]   entry_count_q;
	logic                 queue_empty_q;
	logic                 queue_full_q;

	store_req_t           req;
	entry_t               rdata;

	logic                 accept;
	logic                 is_full;
	logic                 take_new;
	logic [IDX_W-1:0]     best_idx_d;
	logic                 scan_more;
	logic                 need_shift;
	logic                 shift_more;
	logic                 out_free;

	pqse_store u_store (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign is_full  = (cnt_q == CNT_W'(DEPTH));
	assign out_free = !out_valid_q || !out_stall;

	// scan compare: first entry always taken, later ones only if strictly higher
	assign take_new   = (cmp_idx_q == '0) || (rdata.prio > best_pri_q);
	assign best_idx_d = take_new ? cmp_idx_q : best_idx_q;
	assign scan_more  = (CMP_W'(cmp_idx_q) + CMP_W'(1)) < CMP_W'(cnt_q);
	assign need_shift = (CMP_W'(best_idx_d) + CMP_W'(1)) < CMP_W'(cnt_q);
	assign shift_more = (CMP_W'(sh_idx_q) + CMP_W'(2)) < CMP_W'(cnt_q);

	// store port steering
	always_comb begin
		req       = '0;
		req.waddr = cnt_q[IDX_W-1:0];
		req.wdata = '{prio: item_priority, value: item_value};
		case (state_q)
			S_IDLE: begin
				req.we    = accept && (op == OP_ADD) && !is_full;
				req.raddr = '0;
			end
			S_SCAN: begin
				req.raddr = scan_more ? IDX_W'(cmp_idx_q + IDX_W'(1))
				                      : IDX_W'(best_idx_d + IDX_W'(1));
			end
			S_SHIFT: begin
				req.we    = 1'b1;
				req.waddr = sh_idx_q;
				req.wdata = rdata;
				req.raddr = IDX_W'(sh_idx_q + IDX_W'(2));
			end
			default: begin
				req.raddr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// the final step reloads the output register itself
			if (out_valid_q && !out_stall && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_val_q <= '0;
						cmp_idx_q <= '0;
						case (op)
							OP_ADD: begin
								state_q <= S_FIN;
								if (is_full) begin
									res_stat_q <= ST_FULL;
								end else begin
									res_stat_q <= ST_DONE;
									cnt_q      <= CNT_W'(cnt_q + CNT_W'(1));
								end
							end
							OP_EXTRACT: begin
								if (cnt_q == '0) begin
									res_stat_q <= ST_EMPTY;
									state_q    <= S_FIN;
								end else begin
									res_stat_q <= ST_DONE;
									state_q    <= S_SCAN;
								end
							end
							OP_CLEAR: begin
								res_stat_q <= ST_DONE;
								cnt_q      <= '0;
								state_q    <= S_FIN;
							end
							default: begin
								res_stat_q <= ST_DONE;
								state_q    <= S_FIN;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (take_new) begin
						best_pri_q <= rdata.prio;
						res_val_q  <= rdata.value;
					end
					best_idx_q <= best_idx_d;
					if (scan_more) begin
						cmp_idx_q <= IDX_W'(cmp_idx_q + IDX_W'(1));
					end else if (need_shift) begin
						sh_idx_q <= best_idx_d;
						state_q  <= S_SHIFT;
					end else begin
						cnt_q   <= CNT_W'(cnt_q - CNT_W'(1));
						state_q <= S_FIN;
					end
				end
				S_SHIFT: begin
					if (shift_more) begin
						sh_idx_q <= IDX_W'(sh_idx_q + IDX_W'(1));
					end else begin
						cnt_q   <= CNT_W'(cnt_q - CNT_W'(1));
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					// result waits here until the output register is free
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_value_q   <= res_val_q;
						status_q      <= res_stat_q;
						entry_count_q <= COUNT_W'(cnt_q);
						queue_empty_q <= (cnt_q == '0);
						queue_full_q  <= is_full;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_value   = out_value_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;
	assign queue_empty = queue_empty_q;
	assign queue_full  = queue_full_q;

	// fill level never passes the depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("fill level beyond depth");

	// a new result only ever comes out of the final step
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FIN))
		else $error("result raised outside final step");

	// the gap closing only writes inside the occupied region
	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |-> (CMP_W'(sh_idx_q) + CMP_W'(1)) < CMP_W'(cnt_q))
		else $error("shift write beyond fill level");

	// the full and empty flags are never reported together
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(queue_full_q && queue_empty_q))
		else $error("queue reported both full and empty");

endmodule

`default_nettype wire

FILE: tb/priority_queue_scan_extract_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_queue_scan_extract_tb: self-checking bench for the scan queue
// Runs a short table of directed operations, then random add/extract/clear
// traffic in fill, drain and mixed phases. Both sides idle at random.
// Each result is checked field by field against the predictor or the table.
// ----------------------------------------------------------------------------

module priority_queue_scan_extract_tb;

	import pqse_pkg::*;

	localparam real CLK_PERIOD  = 12.0;
	localparam int  RESET_CYCLES = 9;
	localparam int  RANDOM_ITEMS = 1750;
	localparam int  TAIL_CYCLES  = 80;        // idle tail after the last result is checked
	localparam int  CYCLE_LIMIT  = 1000000;

	// op code three is unused by the block: it must behave as a no-op
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

	// one result transaction as the block should present it
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [STAT_W-1:0]  stat;
		logic [COUNT_W-1:0] count;
		logic               empty;
		logic               full;
	} queue_result_t;

	// one row of the directed table; known rows carry a typed-in result
	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [VALUE_W-1:0] value;
		logic [PRIO_W-1:0]  prio;
		logic               known;
		queue_result_t      res;
	} stim_row_t;

	// ------------------------------------------------------------------
	// DUT hookup
	// ------------------------------------------------------------------
	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [OP_W-1:0]    op;
	logic [VALUE_W-1:0] item_value;
	logic [PRIO_W-1:0]  item_priority;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [VALUE_W-1:0] out_value;
	logic [STAT_W-1:0]  status;
	logic [COUNT_W-1:0] entry_count;
	logic               queue_empty;
	logic               queue_full;

	priority_queue_scan_extract dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.item_value   (item_value),
		.item_priority(item_priority),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_value    (out_value),
		.status       (status),
		.entry_count  (entry_count),
		.queue_empty  (queue_empty),
		.queue_full   (queue_full)
	);

	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor state: a private copy of the queue in arrival order
	// ------------------------------------------------------------------
	logic [VALUE_W-1:0] model_value [DEPTH];
	logic [PRIO_W-1:0]  model_prio  [DEPTH];
	int                 model_fill;

	queue_result_t pending_results [$];   // results still owed by the block

	bit no_idle = 1'b0;                   // set for stretches at full rate
	int error_count = 0;
	int results_seen = 0;
	int cycle_count = 0;

	// coverage tallies for the closing summary
	int n_adds = 0;
	int n_extracts = 0;
	int n_clears = 0;
	int n_full_drops = 0;
	int n_empty_misses = 0;
	int peak_fill = 0;

	function automatic queue_result_t make_result(logic [VALUE_W-1:0] v,
			logic [STAT_W-1:0] s, logic [COUNT_W-1:0] c, logic e, logic f);
		queue_result_t r;
		r.value = v;
		r.stat  = s;
		r.count = c;
		r.empty = e;
		r.full  = f;
		return r;
	endfunction

	function automatic stim_row_t stim(logic [OP_W-1:0] o, logic [VALUE_W-1:0] v,
			logic [PRIO_W-1:0] p, logic k, queue_result_t r);
		stim_row_t row;
		row.op    = o;
		row.value = v;
		row.prio  = p;
		row.known = k;
		row.res   = r;
		return row;
	endfunction

	// Applies one operation to the private queue and returns the result
	// that the block owes for it.
	function automatic queue_result_t predict_queue_op(logic [OP_W-1:0] opc,
			logic [VALUE_W-1:0] val, logic [PRIO_W-1:0] pri);
		int                 best;
		logic [VALUE_W-1:0] taken;
		logic [STAT_W-1:0]  st;
		logic [COUNT_W-1:0] cnt;
		taken = '0;
		st    = ST_DONE;
		case (opc)
			OP_ADD: begin
				n_adds++;
				if (model_fill >= DEPTH) begin
					st = ST_FULL;
					n_full_drops++;
				end else begin
					model_value[model_fill] = val;
					model_prio[model_fill]  = pri;
					model_fill++;
				end
			end
			OP_EXTRACT: begin
				n_extracts++;
				if (model_fill == 0) begin
					st = ST_EMPTY;
					n_empty_misses++;
				end else begin
					// strict compare: the earliest of equal priorities wins
					best = 0;
					for (int i = 1; i < model_fill; i++)
						if (model_prio[i] > model_prio[best])
							best = i;
					taken = model_value[best];
					for (int i = best; i + 1 < model_fill; i++) begin
						model_value[i] = model_value[i + 1];
						model_prio[i]  = model_prio[i + 1];
					end
					model_fill--;
				end
			end
			OP_CLEAR: begin
				n_clears++;
				model_fill = 0;
			end
			default: ;
		endcase
		if (model_fill > peak_fill)
			peak_fill = model_fill;
		cnt = COUNT_W'(model_fill);
		return make_result(taken, st, cnt, model_fill == 0, model_fill == DEPTH);
	endfunction

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle)
			return 0;
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(10, 48);
	endfunction

	task automatic report_error(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// Presents one transaction, waits for the block to take it and returns
	// the predicted result. valid stays high across back-to-back items.
	task automatic send_item(input logic [OP_W-1:0] opc,
			input logic [VALUE_W-1:0] val, input logic [PRIO_W-1:0] pri,
			output queue_result_t predicted);
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		op            <= opc;
		item_value    <= val;
		item_priority <= pri;
		do
			@(posedge clk);
		while (in_stall);
		predicted = predict_queue_op(opc, val, pri);
	endtask

	// ------------------------------------------------------------------
	// Output side: random back-pressure, with quiet stretches
	// ------------------------------------------------------------------
	int stall_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!no_idle && $urandom_range(0, 99) < 25) begin
			out_stall  <= 1'b1;
			stall_left <= pick_gap();
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Result checker: each accepted result against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_error($sformatf("result %0d arrived with nothing outstanding",
					results_seen));
			end else begin
				want = pending_results.pop_front();
				if (out_value !== want.value)
					report_error($sformatf("result %0d out_value %h, want %h",
						results_seen, out_value, want.value));
				if (status !== want.stat)
					report_error($sformatf("result %0d status %0d, want %0d",
						results_seen, status, want.stat));
				if (entry_count !== want.count)
					report_error($sformatf("result %0d entry_count %0d, want %0d",
						results_seen, entry_count, want.count));
				if (queue_empty !== want.empty)
					report_error($sformatf("result %0d queue_empty %b, want %b",
						results_seen, queue_empty, want.empty));
				if (queue_full !== want.full)
					report_error($sformatf("result %0d queue_full %b, want %b",
						results_seen, queue_full, want.full));
			end
		end
	end

	// watchdog: generous bound on the slowest legal run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		stim_row_t     directed_rows [$];
		queue_result_t predicted;
		queue_result_t none;
		phase_t        phase;
		int            phase_len;
		int            add_pct;
		int            sent;
		logic [OP_W-1:0]    r_op;
		logic [VALUE_W-1:0] r_val;
		logic [PRIO_W-1:0]  r_pri;

		arst_n        = 1'b0;
		in_valid      = 1'b0;
		op            = OP_ADD;
		item_value    = '0;
		item_priority = '0;
		model_fill    = 0;
		none          = '0;

		// Directed table. Typed-in results only where obvious; the rest
		// goes through the predictor.
		// empty queue: extract miss, clear and the unused code all no-ops
		directed_rows.push_back(stim(OP_EXTRACT, 16'h0000, 8'h00, 1'b1,
			make_result(16'h0000, ST_EMPTY, 6'd0, 1'b1, 1'b0)));
		directed_rows.push_back(stim(OP_CLEAR, 16'hFFFF, 8'hFF, 1'b1,
			make_result(16'h0000, ST_DONE, 6'd0, 1'b1, 1'b0)));
		directed_rows.push_back(stim(OP_UNUSED, 16'hFFFF, 8'hFF, 1'b1,
			make_result(16'h0000, ST_DONE, 6'd0, 1'b1, 1'b0)));
		// field extremes, and a tie at the top priority
		directed_rows.push_back(stim(OP_ADD, 16'hFFFF, 8'h00, 1'b1,
			make_result(16'h0000, ST_DONE, 6'd1, 1'b0, 1'b0)));
		directed_rows.push_back(stim(OP_ADD, 16'h0000, 8'hFF, 1'b0, none));
		directed_rows.push_back(stim(OP_ADD, 16'h1234, 8'hFF, 1'b0, none));
		directed_rows.push_back(stim(OP_ADD, 16'hAAAA, 8'h80, 1'b0, none));
		directed_rows.push_back(stim(OP_ADD, 16'h5555, 8'h7F, 1'b0, none));
		// unused code with entries held: count reported unchanged
		directed_rows.push_back(stim(OP_UNUSED, 16'h0F0F, 8'h3C, 1'b0, none));
		// drain in priority order; middle removals exercise the shift
		directed_rows.push_back(stim(OP_EXTRACT, 16'hFFFF, 8'hFF, 1'b0, none));
		directed_rows.push_back(stim(OP_EXTRACT, 16'h0000, 8'h00, 1'b0, none));
		directed_rows.push_back(stim(OP_EXTRACT, 16'h0000, 8'h00, 1'b0, none));
		directed_rows.push_back(stim(OP_EXTRACT, 16'h0000, 8'h00, 1'b0, none));
		directed_rows.push_back(stim(OP_EXTRACT, 16'h0000, 8'h00, 1'b0, none));
		directed_rows.push_back(stim(OP_EXTRACT, 16'hFFFF, 8'hFF, 1'b1,
			make_result(16'h0000, ST_EMPTY, 6'd0, 1'b1, 1'b0)));
		// clear with entries held, then confirm it is empty
		directed_rows.push_back(stim(OP_ADD, 16'h0001, 8'h01, 1'b0, none));
		directed_rows.push_back(stim(OP_ADD, 16'h0002, 8'h01, 1'b0, none));
		directed_rows.push_back(stim(OP_CLEAR, 16'h0000, 8'h00, 1'b1,
			make_result(16'h0000, ST_DONE, 6'd0, 1'b1, 1'b0)));
		directed_rows.push_back(stim(OP_EXTRACT, 16'h0000, 8'h00, 1'b1,
			make_result(16'h0000, ST_EMPTY, 6'd0, 1'b1, 1'b0)));
		// winner at the head, with the tail shifted down behind it
		directed_rows.push_back(stim(OP_ADD, 16'hFFFF, 8'hFF, 1'b0, none));
		directed_rows.push_back(stim(OP_ADD, 16'h0000, 8'h00, 1'b0, none));
		directed_rows.push_back(stim(OP_ADD, 16'h8001, 8'h00, 1'b0, none));
		directed_rows.push_back(stim(OP_EXTRACT, 16'h0000, 8'h00, 1'b0, none));
		directed_rows.push_back(stim(OP_EXTRACT, 16'h0000, 8'h00, 1'b0, none));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_item(directed_rows[i].op, directed_rows[i].value,
				directed_rows[i].prio, predicted);
			pending_results.push_back(directed_rows[i].known ?
				directed_rows[i].res : predicted);
		end

		// Random part in phases. Fill phases push the queue up to full and
		// into dropped adds, drain phases down to empty misses; mixed phases
		// bring in clears and the unused code. Ties come from a narrow
		// priority band.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			phase     = phase_t'($urandom_range(0, 2));
			phase_len = $urandom_range(20, 100);
			no_idle   = ($urandom_range(0, 3) == 0);
			case (phase)
				PH_FILL:  add_pct = 85;
				PH_DRAIN: add_pct = 20;
				default:  add_pct = 50;
			endcase
			for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
				if (phase == PH_MIXED && $urandom_range(0, 99) < 4)
					r_op = OP_CLEAR;
				else if (phase == PH_MIXED && $urandom_range(0, 99) < 2)
					r_op = OP_UNUSED;
				else if ($urandom_range(0, 99) < add_pct)
					r_op = OP_ADD;
				else
					r_op = OP_EXTRACT;
				r_val = VALUE_W'($urandom_range(0, 65535));
				r_pri = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 255))
					: PRIO_W'($urandom_range(0, 3));
				send_item(r_op, r_val, r_pri, predicted);
				pending_results.push_back(predicted);
				if (r_op != OP_UNUSED)
					sent++;
			end
		end
		in_valid <= 1'b0;
		no_idle  = 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d adds, %0d extracts, %0d clears sent; %0d results checked",
			n_adds, n_extracts, n_clears, results_seen);
		$display("queue peaked at %0d entries; %0d adds dropped full, %0d extracts hit empty",
			peak_fill, n_full_drops, n_empty_misses);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
